[rtl/generic_timer_frames_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros shared by the timer RTL
// Both macros sample on clk and are quiet while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef GENERIC_TIMER_FRAMES_MACROS_SVH
`define GENERIC_TIMER_FRAMES_MACROS_SVH

// Same-cycle implication
`define GTF_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define GTF_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/gtf_pkg.sv]
// ----------------------------------------------------------------------------
// gtf_pkg
// Types, register offsets and helpers for the memory-mapped timer frames.
// ----------------------------------------------------------------------------
package gtf_pkg;

  // Implemented timer frames (1..8); storage always has eight slots
  localparam int NUM_FRAMES  = 8;
  localparam int FRAME_SLOTS = 8;
  localparam int FRAME_W     = 3;
  localparam logic [FRAME_W:0] NUM_FRAMES_L = (FRAME_W + 1)'(NUM_FRAMES);

  typedef enum logic [1:0] {
    ACT_TICK  = 2'd0,
    ACT_READ  = 2'd1,
    ACT_WRITE = 2'd2,
    ACT_NOP   = 2'd3
  } action_t;

  // Control frame offsets
  localparam logic [7:0] CF_FRQ  = 8'h00;
  localparam logic [7:0] CF_NSAR = 8'h04;
  localparam logic [7:0] CF_TIDR = 8'h08;
  localparam logic [7:0] CF_ACR  = 8'h40;
  localparam logic [7:0] CF_VOFF = 8'h80;

  // Timer frame offsets
  localparam logic [7:0] TF_PCT    = 8'h00;
  localparam logic [7:0] TF_VCT    = 8'h08;
  localparam logic [7:0] TF_FRQ    = 8'h10;
  localparam logic [7:0] TF_EL0ACR = 8'h14;
  localparam logic [7:0] TF_VOFF   = 8'h18;
  localparam logic [7:0] TF_P_CVAL = 8'h20;
  localparam logic [7:0] TF_P_TVAL = 8'h28;
  localparam logic [7:0] TF_P_CTL  = 8'h2C;
  localparam logic [7:0] TF_V_CVAL = 8'h30;
  localparam logic [7:0] TF_V_TVAL = 8'h38;
  localparam logic [7:0] TF_V_CTL  = 8'h3C;

  // Control word bit positions
  localparam int CTL_EN   = 0;
  localparam int CTL_MASK = 1;

  typedef struct packed {
    action_t     action;
    logic        control_space;
    logic [2:0]  frame;
    logic [7:0]  offset;
    logic [63:0] write_data;
  } in_item_t;

  typedef struct packed {
    logic [63:0] read_data;
    logic [7:0]  irq_phys_lines;
    logic [7:0]  irq_virt_lines;
  } out_item_t;

  // Comparator state seen by the interrupt stage
  typedef struct packed {
    logic [63:0]                  phys_count;
    logic [FRAME_SLOTS-1:0][63:0] virt_count;
    logic [FRAME_SLOTS-1:0][63:0] phys_cmp;
    logic [FRAME_SLOTS-1:0][63:0] virt_cmp;
    logic [FRAME_SLOTS-1:0][1:0]  phys_ctl;
    logic [FRAME_SLOTS-1:0][1:0]  virt_ctl;
  } cmp_state_t;

  // Comparator condition: enabled and count reached compare
  function automatic logic fired(logic [1:0] ctl, logic [63:0] cnt, logic [63:0] cmp);
    return ctl[CTL_EN] && (cnt >= cmp);
  endfunction

  // ID word: present and virtual bits in the nibble of each implemented frame
  function automatic logic [63:0] tidr_value();
    logic [63:0] v;
    v = '0;
    for (int i = 0; i < FRAME_SLOTS; i++) begin
      if (i < NUM_FRAMES) v[4*i +: 2] = 2'b11;
    end
    return v;
  endfunction

endpackage

[rtl/gtf_core.sv]
// ----------------------------------------------------------------------------
// gtf_core
// Architectural registers and the single-pass register access for one item.
// ----------------------------------------------------------------------------
`include "generic_timer_frames_macros.svh"

module gtf_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                exec_en,
  input  gtf_pkg::in_item_t   item,
  output logic [63:0]         read_data,
  output gtf_pkg::cmp_state_t st
);
  import gtf_pkg::*;

  logic [63:0] pc_r, pc_nxt;
  logic [31:0] freq_r, freq_nxt;
  logic [31:0] nsar_r, nsar_nxt;
  logic [31:0] acr_r, acr_nxt;
  logic [63:0] voff_r [FRAME_SLOTS];
  logic [63:0] voff_nxt [FRAME_SLOTS];
  logic [63:0] vcnt_r [FRAME_SLOTS];   // tracks pc_r - voff_r per frame
  logic [63:0] vcnt_nxt [FRAME_SLOTS];
  logic [63:0] pcmp_r [FRAME_SLOTS];
  logic [63:0] pcmp_nxt [FRAME_SLOTS];
  logic [63:0] vcmp_r [FRAME_SLOTS];
  logic [63:0] vcmp_nxt [FRAME_SLOTS];
  logic [1:0]  pctl_r [FRAME_SLOTS];
  logic [1:0]  pctl_nxt [FRAME_SLOTS];
  logic [1:0]  vctl_r [FRAME_SLOTS];
  logic [1:0]  vctl_nxt [FRAME_SLOTS];
  logic [31:0] el0_r [FRAME_SLOTS];
  logic [31:0] el0_nxt [FRAME_SLOTS];

  logic [FRAME_W-1:0] f;
  logic               frame_ok, is_wr, is_rd, tick;
  logic [63:0]        d, d32, rd;
  logic               virt_sel;
  logic [63:0]        cnt_sel, cmp_sel, diff, tval_new;
  logic [1:0]         ctl_sel;
  logic               ge, gt;
  logic [63:0]        tval_rd, ctl_rd;

  // Operand selection and comparator views
  always_comb begin
    f        = item.frame;
    frame_ok = {1'b0, f} < NUM_FRAMES_L;
    is_wr    = exec_en && (item.action == ACT_WRITE);
    is_rd    = item.action == ACT_READ;
    tick     = exec_en && (item.action == ACT_TICK);
    d        = item.write_data;
    d32      = {32'b0, d[31:0]};
    // Virtual comparator registers sit at 0x30..0x3C
    virt_sel = item.offset[4];
    cnt_sel  = virt_sel ? vcnt_r[f] : pc_r;
    cmp_sel  = virt_sel ? vcmp_r[f] : pcmp_r[f];
    ctl_sel  = virt_sel ? vctl_r[f] : pctl_r[f];
    ge       = cnt_sel >= cmp_sel;
    gt       = ge && (cnt_sel != cmp_sel);
    diff     = cmp_sel - cnt_sel;
    tval_rd  = (ctl_sel[CTL_EN] && !gt) ? {32'b0, diff[31:0]} : 64'b0;
    ctl_rd   = {61'b0, ctl_sel[CTL_EN] && ge, ctl_sel};
    tval_new = cnt_sel + d32;
  end

  // Register access and next state
  always_comb begin
    pc_nxt   = pc_r;
    freq_nxt = freq_r;
    nsar_nxt = nsar_r;
    acr_nxt  = acr_r;
    voff_nxt = voff_r;
    vcnt_nxt = vcnt_r;
    pcmp_nxt = pcmp_r;
    vcmp_nxt = vcmp_r;
    pctl_nxt = pctl_r;
    vctl_nxt = vctl_r;
    el0_nxt  = el0_r;
    rd       = '0;

    if (tick) begin
      pc_nxt = pc_r + 64'd1;
      for (int i = 0; i < FRAME_SLOTS; i++) vcnt_nxt[i] = vcnt_r[i] + 64'd1;
    end

    if (item.control_space) begin
      case (item.offset)
        CF_FRQ: begin
          if (is_wr) freq_nxt = d[31:0];
          rd = {32'b0, freq_r};
        end
        CF_NSAR: begin
          if (is_wr) nsar_nxt = d[31:0];
          rd = {32'b0, nsar_r};
        end
        CF_TIDR: rd = tidr_value();
        CF_ACR: begin
          if (is_wr) acr_nxt = d[31:0];
          rd = {32'b0, acr_r};
        end
        CF_VOFF: begin
          if (is_wr) begin
            voff_nxt[f] = d;
            vcnt_nxt[f] = pc_r - d;
          end
          rd = voff_r[f];
        end
        default: rd = '0;
      endcase
    end else if (frame_ok) begin
      case (item.offset)
        TF_PCT:    rd = pc_r;
        TF_VCT:    rd = vcnt_r[f];
        TF_FRQ:    rd = {32'b0, freq_r};
        TF_EL0ACR: begin
          if (is_wr) el0_nxt[f] = d[31:0];
          rd = {32'b0, el0_r[f]};
        end
        TF_VOFF:   rd = voff_r[f];
        TF_P_CVAL: begin
          if (is_wr) pcmp_nxt[f] = d;
          rd = pcmp_r[f];
        end
        TF_P_TVAL: begin
          if (is_wr) pcmp_nxt[f] = tval_new;
          rd = tval_rd;
        end
        TF_P_CTL: begin
          if (is_wr) pctl_nxt[f] = d[1:0];
          rd = ctl_rd;
        end
        TF_V_CVAL: begin
          if (is_wr) vcmp_nxt[f] = d;
          rd = vcmp_r[f];
        end
        TF_V_TVAL: begin
          if (is_wr) vcmp_nxt[f] = tval_new;
          rd = tval_rd;
        end
        TF_V_CTL: begin
          if (is_wr) vctl_nxt[f] = d[1:0];
          rd = ctl_rd;
        end
        default: rd = '0;
      endcase
    end

    read_data = is_rd ? rd : 64'b0;
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r   <= '0;
      freq_r <= '0;
      nsar_r <= '0;
      acr_r  <= '0;
      for (int i = 0; i < FRAME_SLOTS; i++) begin
        voff_r[i] <= '0;
        vcnt_r[i] <= '0;
        pcmp_r[i] <= '0;
        vcmp_r[i] <= '0;
        pctl_r[i] <= '0;
        vctl_r[i] <= '0;
        el0_r[i]  <= '0;
      end
    end else begin
      pc_r   <= pc_nxt;
      freq_r <= freq_nxt;
      nsar_r <= nsar_nxt;
      acr_r  <= acr_nxt;
      voff_r <= voff_nxt;
      vcnt_r <= vcnt_nxt;
      pcmp_r <= pcmp_nxt;
      vcmp_r <= vcmp_nxt;
      pctl_r <= pctl_nxt;
      vctl_r <= vctl_nxt;
      el0_r  <= el0_nxt;
    end
  end

  // Comparator state for the interrupt stage
  always_comb begin
    st.phys_count = pc_r;
    for (int i = 0; i < FRAME_SLOTS; i++) begin
      st.virt_count[i] = vcnt_r[i];
      st.phys_cmp[i]   = pcmp_r[i];
      st.virt_cmp[i]   = vcmp_r[i];
      st.phys_ctl[i]   = pctl_r[i];
      st.virt_ctl[i]   = vctl_r[i];
    end
  end

  // Counter advances by exactly one per tick
  `GTF_ASSERT_NXT(a_tick_inc, tick, pc_r == $past(pc_r) + 64'd1, "tick did not advance counter")

  // Counter holds when no item executes
  `GTF_ASSERT_NXT(a_idle_hold, !exec_en, $stable(pc_r), "counter moved without an item")

  // Virtual count stays equal to counter minus offset
  for (genvar g = 0; g < FRAME_SLOTS; g++) begin : g_vchk
    `GTF_ASSERT_IMP(a_vcnt, 1'b1, vcnt_r[g] + voff_r[g] == pc_r, "virtual count out of step")
  end

endmodule

[rtl/gtf_irq.sv]
// ----------------------------------------------------------------------------
// gtf_irq
// Interrupt lines per frame: comparator fired and not masked.
// ----------------------------------------------------------------------------
module gtf_irq (
  input  gtf_pkg::cmp_state_t st,
  output logic [7:0]          phys_irq,
  output logic [7:0]          virt_irq
);
  import gtf_pkg::*;

  // Sixteen independent compares, one per comparator
  always_comb begin
    phys_irq = '0;
    virt_irq = '0;
    for (int i = 0; i < FRAME_SLOTS; i++) begin
      if (i < NUM_FRAMES) begin
        phys_irq[i] = fired(st.phys_ctl[i], st.phys_count, st.phys_cmp[i]) &&
                      !st.phys_ctl[i][CTL_MASK];
        virt_irq[i] = fired(st.virt_ctl[i], st.virt_count[i], st.virt_cmp[i]) &&
                      !st.virt_ctl[i][CTL_MASK];
      end
    end
  end

endmodule

[rtl/generic_timer_frames.sv]
// ----------------------------------------------------------------------------
// generic_timer_frames: counter, virtual offsets and comparators per frame.
// Stages: input register, access pass into stage 2, interrupt compare.
// Throughput 1 item per cycle; the out_ready stall holds all three stages.
// Synchronous active-low reset clears the valid bits, the registers and the counter; payloads are not reset.
// ----------------------------------------------------------------------------
`include "generic_timer_frames_macros.svh"

module generic_timer_frames (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  gtf_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_ready,
  output gtf_pkg::out_item_t out_item
);
  import gtf_pkg::*;

  in_item_t    in_r;
  logic        in_v_r, in_v_nxt;
  logic [63:0] rd_r;
  logic        s2_v_r, s2_v_nxt;
  out_item_t   out_r;
  logic        out_v_r, out_v_nxt;

  logic        out_adv, s2_adv, exec;
  logic [63:0] core_rd;
  cmp_state_t  st;
  logic [7:0]  phys_irq, virt_irq;

  // Pipeline flow: stage 2 only moves with the output register, so the
  // state it sees is exactly the state right after its own item
  always_comb begin
    out_adv   = !out_v_r || out_ready;
    s2_adv    = !s2_v_r || out_adv;
    exec      = in_v_r && s2_adv;
    in_ready  = !in_v_r || exec;
    in_v_nxt  = in_valid ? 1'b1 : (exec ? 1'b0 : in_v_r);
    s2_v_nxt  = s2_adv ? exec : s2_v_r;
    out_v_nxt = out_adv ? s2_v_r : out_v_r;
  end

  gtf_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .exec_en   (exec),
    .item      (in_r),
    .read_data (core_rd),
    .st        (st)
  );

  gtf_irq u_irq (
    .st       (st),
    .phys_irq (phys_irq),
    .virt_irq (virt_irq)
  );

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      in_v_r  <= in_ready ? in_v_nxt : in_v_r;
      s2_v_r  <= s2_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) in_r <= in_item;
    if (exec) rd_r <= core_rd;
    if (out_adv && s2_v_r) begin
      out_r.read_data      <= rd_r;
      out_r.irq_phys_lines <= phys_irq;
      out_r.irq_virt_lines <= virt_irq;
    end
  end

  assign out_valid = out_v_r;
  assign out_item  = out_r;

  // An executed item lands in stage 2
  `GTF_ASSERT_NXT(a_exec_s2, exec, s2_v_r, "executed item lost before stage 2")
  // State is frozen while stage 2 waits on the output
  `GTF_ASSERT_NXT(a_s2_hold, s2_v_r && !out_adv, $stable(st.phys_count), "state moved under stage 2")
  // A waiting stage 2 item moves out as soon as the output frees up
  `GTF_ASSERT_NXT(a_s2_out, s2_v_r && out_adv, out_v_r, "stage 2 item dropped")

endmodule

[tb/timer_frames_checker.sv]
// ----------------------------------------------------------------------------
// timer_frames_checker
// Watches both channels of the timer frames block. It keeps a shadow copy of
// the counter, the frame registers and the comparators, and works out the
// reply for every accepted item. Each accepted reply is compared field by
// field with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module timer_frames_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  gtf_pkg::in_item_t  in_item,
  input  logic               out_valid,
  input  logic               out_ready,
  input  gtf_pkg::out_item_t out_item,
  output int                 mismatches,
  output int                 replies_owed
);
  import gtf_pkg::*;

  // Shadow register file
  logic [63:0] count_q;
  logic [31:0] freq_q;
  logic [31:0] nsar_q;
  logic [31:0] acr_q;
  logic [63:0] voff_q   [8];
  logic [63:0] pcmp_q   [8];
  logic [63:0] vcmp_q   [8];
  logic [1:0]  pctl_q   [8];
  logic [1:0]  vctl_q   [8];
  logic [31:0] el0acr_q [8];

  // Predicted replies, oldest first
  out_item_t predicted_replies [$];
  int        errs = 0;

  // Comparator has gone off: enabled and count at or past compare
  function automatic logic reached(logic [1:0] ctl, logic [63:0] cnt, logic [63:0] cmp);
    return ctl[CTL_EN] & (cnt >= cmp);
  endfunction

  // CTL view: stored enable/mask plus live status in bit 2
  function automatic logic [63:0] ctl_word(logic [1:0] ctl, logic [63:0] cnt,
                                           logic [63:0] cmp);
    return {61'd0, reached(ctl, cnt, cmp), ctl};
  endfunction

  // TVAL view: zero when disabled or already past compare
  function automatic logic [63:0] tval_word(logic [1:0] ctl, logic [63:0] cnt,
                                            logic [63:0] cmp);
    logic [63:0] diff;
    diff = cmp - cnt;
    if (!ctl[CTL_EN] || cnt > cmp) return 64'd0;
    return {32'd0, diff[31:0]};
  endfunction

  // CNTTIDR: present and virtual flags for implemented frames
  function automatic logic [63:0] id_word();
    logic [63:0] w;
    w = 64'd0;
    for (int i = 0; i < NUM_FRAMES; i++) w = w | (64'h3 << (4 * i));
    return w;
  endfunction

  // Apply one item to the shadow state and return the reply it causes
  function automatic out_item_t predict_access(in_item_t it);
    out_item_t   r;
    logic        wr;
    logic [63:0] d;
    logic [63:0] pc;
    logic [63:0] vc;
    logic [63:0] v;
    int unsigned f;
    r  = '0;
    v  = 64'd0;
    f  = 32'(it.frame);
    d  = it.write_data;
    wr = (it.action == ACT_WRITE);
    if (it.action == ACT_TICK) begin
      count_q = count_q + 64'd1;
    end else if (it.action == ACT_READ || wr) begin
      if (it.control_space) begin
        case (it.offset)
          CF_FRQ: begin
            if (wr) freq_q = d[31:0];
            v = {32'd0, freq_q};
          end
          CF_NSAR: begin
            if (wr) nsar_q = d[31:0];
            v = {32'd0, nsar_q};
          end
          CF_TIDR: v = id_word();
          CF_ACR: begin
            if (wr) acr_q = d[31:0];
            v = {32'd0, acr_q};
          end
          CF_VOFF: begin
            if (wr) voff_q[f] = d;
            v = voff_q[f];
          end
          default: v = 64'd0;
        endcase
      end else if (f < NUM_FRAMES) begin
        pc = count_q;
        vc = count_q - voff_q[f];
        case (it.offset)
          TF_PCT: v = pc;
          TF_VCT: v = vc;
          TF_FRQ: v = {32'd0, freq_q};
          TF_EL0ACR: begin
            if (wr) el0acr_q[f] = d[31:0];
            v = {32'd0, el0acr_q[f]};
          end
          TF_VOFF: v = voff_q[f];
          TF_P_CVAL: begin
            if (wr) pcmp_q[f] = d;
            v = pcmp_q[f];
          end
          TF_P_TVAL: begin
            if (wr) pcmp_q[f] = pc + {32'd0, d[31:0]};
            v = tval_word(pctl_q[f], pc, pcmp_q[f]);
          end
          TF_P_CTL: begin
            if (wr) pctl_q[f] = d[1:0];
            v = ctl_word(pctl_q[f], pc, pcmp_q[f]);
          end
          TF_V_CVAL: begin
            if (wr) vcmp_q[f] = d;
            v = vcmp_q[f];
          end
          TF_V_TVAL: begin
            if (wr) vcmp_q[f] = vc + {32'd0, d[31:0]};
            v = tval_word(vctl_q[f], vc, vcmp_q[f]);
          end
          TF_V_CTL: begin
            if (wr) vctl_q[f] = d[1:0];
            v = ctl_word(vctl_q[f], vc, vcmp_q[f]);
          end
          default: v = 64'd0;
        endcase
      end
      if (!wr) r.read_data = v;
    end
    // Interrupt lines after the item
    for (int i = 0; i < NUM_FRAMES; i++) begin
      r.irq_phys_lines[i] = reached(pctl_q[i], count_q, pcmp_q[i]) & ~pctl_q[i][CTL_MASK];
      r.irq_virt_lines[i] = reached(vctl_q[i], count_q - voff_q[i], vcmp_q[i]) &
                            ~vctl_q[i][CTL_MASK];
    end
    return r;
  endfunction

  // Predict on accepted items, compare on accepted replies
  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      count_q = 64'd0;
      freq_q  = 32'd0;
      nsar_q  = 32'd0;
      acr_q   = 32'd0;
      for (int i = 0; i < 8; i++) begin
        voff_q[i]   = 64'd0;
        pcmp_q[i]   = 64'd0;
        vcmp_q[i]   = 64'd0;
        pctl_q[i]   = 2'd0;
        vctl_q[i]   = 2'd0;
        el0acr_q[i] = 32'd0;
      end
      predicted_replies.delete();
    end else begin
      if (in_valid && in_ready) predicted_replies.push_back(predict_access(in_item));
      if (out_valid && out_ready) begin
        if (predicted_replies.size() == 0) begin
          if (errs < 10)
            $display("unexpected reply: read_data %h phys irq %h virt irq %h",
                     out_item.read_data, out_item.irq_phys_lines, out_item.irq_virt_lines);
          errs++;
        end else begin
          want = predicted_replies.pop_front();
          if (want.read_data !== out_item.read_data ||
              want.irq_phys_lines !== out_item.irq_phys_lines ||
              want.irq_virt_lines !== out_item.irq_virt_lines) begin
            if (errs < 10)
              $display("reply mismatch: read_data exp %h got %h, phys irq exp %h got %h, %s",
                       want.read_data, out_item.read_data, want.irq_phys_lines,
                       out_item.irq_phys_lines,
                       $sformatf("virt irq exp %h got %h", want.irq_virt_lines,
                                 out_item.irq_virt_lines));
            errs++;
          end
        end
      end
    end
    mismatches   <= errs;
    replies_owed <= predicted_replies.size();
  end

endmodule

[tb/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the timer frames block. A directed pass walks the
// control and timer frame maps, read-only and unmapped offsets, comparator
// firing and masking and a wrapping virtual count; random traffic follows,
// biased toward compare values near the live count. Both channels idle at
// random except in one calm stretch.
// ----------------------------------------------------------------------------
module testbench;
  import gtf_pkg::*;

  localparam int RUN_ITEMS   = 750;
  localparam int CYCLE_LIMIT = 200000;

  logic      clk      = 1'b0;
  logic      rst_n    = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_item  = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_item;
  int        mismatches;
  int        replies_owed;
  logic      calm = 1'b0;
  logic [63:0] ticks_sent = 64'd0;
  int        cycles = 0;

  // Mapped offsets used by the random traffic
  logic [7:0] timer_offs [11] = '{TF_PCT, TF_VCT, TF_FRQ, TF_EL0ACR, TF_VOFF, TF_P_CVAL,
                                  TF_P_TVAL, TF_P_CTL, TF_V_CVAL, TF_V_TVAL, TF_V_CTL};
  logic [7:0] ctrl_offs  [5]  = '{CF_FRQ, CF_NSAR, CF_TIDR, CF_ACR, CF_VOFF};

  generic_timer_frames uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  timer_frames_checker checker_i (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_item      (in_item),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_item     (out_item),
    .mismatches   (mismatches),
    .replies_owed (replies_owed)
  );

  // Clock, period 8
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Reply side back-pressure
  always @(posedge clk) begin
    out_ready <= calm || ($urandom_range(99) >= 14);
  end

  // Offer one item, maybe after a short gap; returns at the accepting edge
  task automatic drive_item(in_item_t it);
    if (!calm && $urandom_range(99) < 14) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (it.action == ACT_TICK) ticks_sent = ticks_sent + 64'd1;
  endtask

  task automatic put(action_t a, logic cs, logic [2:0] f, logic [7:0] off, logic [63:0] d);
    in_item_t it;
    it.action        = a;
    it.control_space = cs;
    it.frame         = f;
    it.offset        = off;
    it.write_data    = d;
    drive_item(it);
  endtask

  // Hold the sender until every predicted reply has arrived
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (replies_owed != 0) @(posedge clk);
  endtask

  // Random item, compare values often close to the live count
  function automatic in_item_t random_item();
    in_item_t    it;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 35)      it.action = ACT_TICK;
    else if (pick < 66) it.action = ACT_READ;
    else if (pick < 95) it.action = ACT_WRITE;
    else                it.action = ACT_NOP;
    it.control_space = ($urandom_range(99) < 25);
    it.frame         = 3'($urandom_range(7));
    if ($urandom_range(99) < 12)  it.offset = 8'($urandom_range(255));
    else if (it.control_space)    it.offset = ctrl_offs[$urandom_range(4)];
    else                          it.offset = timer_offs[$urandom_range(10)];
    case ($urandom_range(9))
      0, 9:    it.write_data = {$urandom, $urandom};
      1:       it.write_data = '1;
      2:       it.write_data = 64'd0;
      3, 4, 5, 6:
               it.write_data = ticks_sent + 64'($urandom_range(40)) - 64'd8;
      default: it.write_data = 64'($urandom_range(24));
    endcase
    return it;
  endfunction

  initial begin
    in_item_t it;
    int       n;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Control frame map and storage widths
    put(ACT_READ,  1'b1, 3'd0, CF_TIDR, 64'd0);
    put(ACT_WRITE, 1'b1, 3'd0, CF_FRQ, '1);
    put(ACT_READ,  1'b0, 3'd7, TF_FRQ, 64'd0);
    put(ACT_WRITE, 1'b1, 3'd2, CF_NSAR, 64'h1234_5678_9abc_def0);
    put(ACT_WRITE, 1'b1, 3'd0, CF_ACR, '1);
    put(ACT_WRITE, 1'b1, 3'd3, CF_VOFF, '1);
    put(ACT_READ,  1'b0, 3'd3, TF_VOFF, 64'd0);
    put(ACT_READ,  1'b0, 3'd3, TF_VCT, 64'd0);
    // Read-only and unmapped writes are dropped
    put(ACT_WRITE, 1'b0, 3'd1, TF_PCT, '1);
    put(ACT_WRITE, 1'b1, 3'd0, CF_TIDR, '1);
    put(ACT_READ,  1'b1, 3'd0, 8'hff, 64'd0);
    put(ACT_WRITE, 1'b0, 3'd4, 8'h44, '1);
    // Physical comparator fires, then gets masked; status bit write ignored
    put(ACT_WRITE, 1'b0, 3'd0, TF_P_CVAL, 64'd3);
    put(ACT_WRITE, 1'b0, 3'd0, TF_P_CTL, 64'h5);
    repeat (4) put(ACT_TICK, 1'b0, 3'd0, 8'h00, 64'd0);
    put(ACT_READ,  1'b0, 3'd0, TF_P_CTL, 64'd0);
    put(ACT_READ,  1'b0, 3'd0, TF_P_TVAL, 64'd0);
    put(ACT_WRITE, 1'b0, 3'd0, TF_P_CTL, 64'h3);
    // Virtual count below zero, TVAL write wraps compare
    put(ACT_WRITE, 1'b1, 3'd5, CF_VOFF, 64'd100);
    put(ACT_WRITE, 1'b0, 3'd5, TF_V_TVAL, 64'hffff_ffff);
    put(ACT_WRITE, 1'b0, 3'd5, TF_V_CTL, 64'h1);
    put(ACT_READ,  1'b0, 3'd5, TF_V_CVAL, 64'd0);
    put(ACT_READ,  1'b0, 3'd5, TF_V_TVAL, 64'd0);
    put(ACT_WRITE, 1'b0, 3'd2, TF_EL0ACR, '1);
    put(ACT_READ,  1'b0, 3'd2, TF_EL0ACR, 64'd0);
    put(ACT_NOP,   1'b0, 3'd0, 8'h00, '1);
    drain();

    // Random traffic; calm stretch in the middle, one full drain later
    n = 0;
    while (n < RUN_ITEMS) begin
      calm = (n >= 300 && n < 450);
      if (n == 520) begin
        drain();
        n++;
      end
      it = random_item();
      drive_item(it);
      if (it.action != ACT_NOP) n++;
    end
    calm = 1'b0;
    drain();
    repeat (8) @(posedge clk);

    if (mismatches == 0 && replies_owed == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
